// ----- sv/hccd_pkg.sv -----
// ---------------------------------------------------------------------------
// hccd_pkg
// Types and codes shared by the hall-call car dispatcher.
// ---------------------------------------------------------------------------
package hccd_pkg;

   localparam int FLOOR_BITS = 4;
   localparam int DIR_BITS   = 2;
   localparam int IDX_BITS   = 3;
   localparam int CSR_BITS   = 4;

   localparam logic [DIR_BITS-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_UP   = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_DOWN = 2'd2;

   localparam logic [CSR_BITS-1:0] ACTIVE_RESET = 4'd8;

   typedef logic [FLOOR_BITS-1:0] floor_type;
   typedef logic [DIR_BITS-1:0]   dir_type;

   // One car's status entry (13 bits).
   typedef struct packed {
      floor_type floor;
      floor_type target;
      dir_type   dir;
      logic      door;
      logic      fault;
      logic      moving;
   } entry_type;

   // Hall call under dispatch.
   typedef struct packed {
      floor_type floor;
      dir_type   dir;
   } call_type;

   // Running best of the current pass.
   typedef struct packed {
      logic      found;
      floor_type gap;
   } best_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ----- sv/hccd_judge.sv -----
// ---------------------------------------------------------------------------
// hccd_judge
// Decides whether one car entry beats the running best of a scan pass.
// ---------------------------------------------------------------------------
module hccd_judge
   import hccd_pkg::*;
(
   input  entry_type entry,
   input  call_type  call,
   input  logic      pass2,
   input  best_type  best,
   output logic      take,
   output floor_type gap
);

   floor_type tdist;
   logic      passed;
   logic      closer;
   logic      dir_ok;
   logic      strict_ok;

   always_comb begin
      gap    = (entry.floor > call.floor) ? entry.floor - call.floor
                                          : call.floor - entry.floor;
      tdist  = (entry.target > entry.floor) ? entry.target - entry.floor
                                            : entry.floor - entry.target;
      // skip a car that has already gone by the call floor
      passed = ((entry.floor > call.floor) && (entry.dir == DIR_UP)) ||
               ((entry.floor < call.floor) && (entry.dir == DIR_DOWN));
      // first pass keeps the lower index on a tie, second the higher
      if (pass2) begin
         closer = !(best.found && (gap > best.gap));
      end else begin
         closer = !(best.found && (gap >= best.gap));
      end
      dir_ok    = (entry.dir == call.dir) || (entry.dir == DIR_NONE);
      strict_ok = !entry.door && !(entry.moving && (gap > tdist));
      take      = !passed && closer && dir_ok && !entry.fault && (pass2 || strict_ok);
   end

endmodule

// ----- sv/hall_call_car_dispatch_top.sv -----
// ---------------------------------------------------------------------------
// hall_call_car_dispatch_top
// Car status table with two-pass hall-call dispatch.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one word per item. tuser = 0 writes one car's status entry
//   and returns nothing; tuser = 1 is a hall call and returns one rsp word.
//   csr_* writes active_cars, the number of cars scanned from index 0; it is
//   always ready and is meant to be written while the block is idle.
// Throughput:
//   An update leaves the block idle; the next word is taken the cycle after.
//   A hall call scans the status memory one entry per cycle over its single
//   registered read port, n = min(active_cars, MAX_CARS) entries per pass;
//   the second pass runs only when the first finds no car. No new word is
//   taken until the call's response is loaded.
// Reset:
//   All entries read as zero (floor 0, idle, door closed) until written;
//   active_cars returns to 8. No clearing pass is needed.
// Stall:
//   The result sits in an output register; a new word is accepted while it
//   waits, and the next call holds at the end of its scan until rsp drains.
// ---------------------------------------------------------------------------
module hall_call_car_dispatch_top
   import hccd_pkg::*;
#(
   parameter int MAX_CARS = 8
)
(
   input  logic                clock,
   input  logic                reset,
   // req_tdata: car_index[2:0], car_floor[6:3], car_target[10:7],
   // car_direction[12:11], door_open[13], car_faulted[14], car_moving[15],
   // call_floor[19:16], call_direction[21:20], zero [23:22]
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,
   input  logic                req_tuser,       // mode
   // rsp_tdata: chosen_car[2:0], hall_floor[6:3], hall_direction[8:7],
   // zero [15:9]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,
   output logic                rsp_tuser,       // car_found
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_BITS-1:0] csr_data
);

   localparam int AW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
   localparam int CW = $clog2(MAX_CARS + 1);

   // status memory
   entry_type           mem [MAX_CARS];
   logic [MAX_CARS-1:0] vld_ff;
   entry_type           rd_data_ff;
   logic                rd_vld_ff;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   entry_type           wr_data;

   state_type           state_ff, state_in;
   logic                pass2_ff, pass2_in;
   logic [CW-1:0]       iss_ff, iss_in;
   logic                rv_ff;
   logic [AW-1:0]       ridx_ff;
   logic                found_ff, found_in;
   logic [AW-1:0]       best_ff, best_in;
   floor_type           bestd_ff, bestd_in;
   call_type            call_ff;
   logic [CSR_BITS-1:0] active_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff;
   logic [AW-1:0]       rsp_car_ff;
   call_type            rsp_call_ff;
   logic                rsp_load;

   logic                req_acc;
   logic [4:0]          act_ext;
   logic [4:0]          n_wide;
   logic [CW-1:0]       n_cars;
   logic                last;
   entry_type           cur_entry;
   best_type            best_cur;
   logic                take;
   floor_type           gap;

   assign req_acc   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   assign act_ext = {1'b0, active_ff};
   assign n_wide  = (act_ext > 5'(MAX_CARS)) ? 5'(MAX_CARS) : act_ext;
   assign n_cars  = n_wide[CW-1:0];
   assign last    = ((CW'(ridx_ff) + CW'(1)) == n_cars);

   // status update write
   assign wr_en   = req_acc && !req_tuser && (5'(req_tdata[2:0]) < 5'(MAX_CARS));
   assign wr_addr = AW'(req_tdata[2:0]);
   assign wr_data = '{floor:  req_tdata[6:3],
                      target: req_tdata[10:7],
                      dir:    req_tdata[12:11],
                      door:   req_tdata[13],
                      fault:  req_tdata[14],
                      moving: req_tdata[15]};
   assign rd_addr = iss_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
         ridx_ff    <= rd_addr;
      end
   end

   // never-written entries read as the reset status
   assign cur_entry = rd_vld_ff ? rd_data_ff : '0;
   assign best_cur  = '{found: found_ff, gap: bestd_ff};

   hccd_judge u_judge (
      .entry (cur_entry),
      .call  (call_ff),
      .pass2 (pass2_ff),
      .best  (best_cur),
      .take  (take),
      .gap   (gap)
   );

   always_comb begin
      state_in     = state_ff;
      pass2_in     = pass2_ff;
      iss_in       = iss_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      bestd_in     = bestd_ff;
      rd_en        = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tuser) begin
               pass2_in = 1'b0;
               iss_in   = '0;
               found_in = 1'b0;
               state_in = (n_cars == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (iss_ff < n_cars) begin
               rd_en  = 1'b1;
               iss_in = iss_ff + CW'(1);
            end
            if (rv_ff) begin
               if (take) begin
                  found_in = 1'b1;
                  best_in  = ridx_ff;
                  bestd_in = gap;
               end
               if (last) begin
                  // rescan with loose rules when the strict pass finds nothing
                  if (!pass2_ff && !found_in) begin
                     pass2_in = 1'b1;
                     iss_in   = '0;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass2_ff     <= 1'b0;
         iss_ff       <= '0;
         rv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         vld_ff       <= '0;
         active_ff    <= ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass2_ff     <= pass2_in;
         iss_ff       <= iss_in;
         rv_ff        <= rd_en;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            active_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff  <= best_in;
      bestd_ff <= bestd_in;
      if (req_acc && req_tuser) begin
         call_ff <= '{floor: req_tdata[19:16], dir: req_tdata[21:20]};
      end
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_car_ff   <= found_ff ? best_ff : '0;
         rsp_call_ff  <= call_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {7'b0, rsp_call_ff.dir, rsp_call_ff.floor, 3'(rsp_car_ff)};

endmodule
